### hdl/tgi_pkg.sv
package tgi_pkg;

  // Fixed field widths
  localparam int unsigned COORD_W   = 12;
  localparam int unsigned SIZE_W    = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned CORNER_W  = 3;

  localparam logic [SIZE_W-1:0] SIZE_RST = 5'd16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

  // Item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_WRITE,
    ST_CORNER,
    ST_DRAIN,
    ST_RESULT
  } tgi_state_e;

  typedef struct packed {
    logic                load;    // capture item, saturate coordinates
    logic                addr;    // compute base cell address
    logic                write;   // store sample at base address
    logic                issue;   // read one corner into the MAC pipe
    logic [CORNER_W-1:0] corner;  // {x, y, z} upper-neighbor select
    logic                result;  // round, saturate, load output register
  } tgi_cmd_t;

  typedef struct packed {
    logic is_query;
  } tgi_status_t;

endpackage

### hdl/tgi_ctrl.sv
module tgi_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  tgi_pkg::tgi_status_t status_i,
  output tgi_pkg::tgi_cmd_t    cmd_o
);
  import tgi_pkg::*;

  localparam int unsigned NUM_CORNERS  = 8;
  // MAC pipe depth behind the store read: weight, product, accumulate
  localparam int unsigned DRAIN_CYCLES = 3;

  localparam logic [CORNER_W-1:0] CORNER_LAST = CORNER_W'(NUM_CORNERS - 1);
  localparam logic [CORNER_W-1:0] DRAIN_LAST  = CORNER_W'(DRAIN_CYCLES - 1);

  tgi_state_e          state_q, state_d;
  logic [CORNER_W-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd_o.addr = 1'b1;
        cnt_d      = '0;
        state_d    = status_i.is_query ? ST_CORNER : ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_CORNER: begin
        cmd_o.issue  = 1'b1;
        cmd_o.corner = cnt_q;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == CORNER_LAST) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DRAIN_LAST) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.result = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### hdl/tgi_datapath.sv
module tgi_datapath #(
  parameter int unsigned AXIS_MAX    = 16,
  parameter int unsigned FRAC_BITS   = 8,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tgi_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tgi_pkg::SIZE_W-1:0]         cfg_data_i,
  input  logic                               opcode_i,
  input  logic [tgi_pkg::COORD_W-1:0]        coord_x_i,
  input  logic [tgi_pkg::COORD_W-1:0]        coord_y_i,
  input  logic [tgi_pkg::COORD_W-1:0]        coord_z_i,
  input  logic signed [SAMPLE_BITS-1:0]      sample_value_i,
  input  tgi_pkg::tgi_cmd_t                  cmd_i,
  output tgi_pkg::tgi_status_t               status_o,
  output logic signed [tgi_pkg::OUT_W-1:0]   interp_value_o,
  output logic                               coord_clamped_o
);
  import tgi_pkg::*;

  localparam int unsigned IDX_W   = $clog2(AXIS_MAX);
  localparam int unsigned EFF_W   = IDX_W + 1;
  localparam int unsigned SYZ_W   = 2 * EFF_W;
  localparam int unsigned DEPTH   = AXIS_MAX * AXIS_MAX * AXIS_MAX;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned SUM_W   = IDX_W + SYZ_W + 1;
  localparam int unsigned CMP_W   = (COORD_W > IDX_W + FRAC_BITS) ? COORD_W
                                                                  : IDX_W + FRAC_BITS;
  localparam int unsigned WF_W    = FRAC_BITS + 1;
  localparam int unsigned WXY_W   = 2 * WF_W;
  localparam int unsigned W_W     = 3 * WF_W;
  localparam int unsigned SHIFT   = 3 * FRAC_BITS;
  localparam int unsigned ACC_W   = SAMPLE_BITS + SHIFT + 4;
  localparam int unsigned PROD_W  = ACC_W;
  localparam int unsigned V_W     = ACC_W - SHIFT;

  localparam logic [WF_W-1:0] ONE_FRAC = WF_W'(1) << FRAC_BITS;
  localparam logic signed [V_W-1:0] V_HI = V_W'({(SAMPLE_BITS-1){1'b1}});
  localparam logic signed [V_W-1:0] V_LO = ~V_HI;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (SHIFT - 1);

  // size register -> last usable index (0 acts as 1, above AXIS_MAX clips)
  function automatic logic [IDX_W-1:0] size_to_lim(input logic [SIZE_W-1:0] s);
    logic [IDX_W-1:0] lim;
    if (s == '0) begin
      lim = '0;
    end else if (int'(s) > int'(AXIS_MAX)) begin
      lim = IDX_W'(AXIS_MAX - 1);
    end else begin
      lim = IDX_W'(s - 1'b1);
    end
    return lim;
  endfunction

  // configuration
  logic [SIZE_W-1:0] size_q [3];
  logic [IDX_W-1:0]  lim    [3];
  logic [EFF_W-1:0]  sz_eff;
  logic [SYZ_W-1:0]  syz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q[0] <= SIZE_RST;
      size_q[1] <= SIZE_RST;
      size_q[2] <= SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SIZE_X: size_q[0] <= cfg_data_i;
        CFG_SIZE_Y: size_q[1] <= cfg_data_i;
        CFG_SIZE_Z: size_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lim[a] = size_to_lim(size_q[a]);
    end
  end

  assign sz_eff = EFF_W'(lim[2]) + EFF_W'(1);

  // x stride, refreshed every cycle from the size registers
  always_ff @(posedge clk_i) begin
    syz_q <= (SYZ_W'(lim[1]) + SYZ_W'(1)) * SYZ_W'(sz_eff);
  end

  // item capture with coordinate saturation
  logic [COORD_W-1:0]   coord [3];
  logic [CMP_W-1:0]     c_ext [3];
  logic [CMP_W-1:0]     c_lim [3];
  logic [CMP_W-1:0]     c_sat [3];
  logic [2:0]           c_ovr;
  logic [2:0]           c_inr;

  logic                   op_q;
  logic [IDX_W-1:0]       base_q [3];
  logic [FRAC_BITS-1:0]   frac_q [3];
  logic                   flag_q;
  logic                   in_range_q;
  logic [SAMPLE_BITS-1:0] wdata_q;

  assign coord[0] = coord_x_i;
  assign coord[1] = coord_y_i;
  assign coord[2] = coord_z_i;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      c_ext[a] = CMP_W'(coord[a]);
      c_lim[a] = CMP_W'(lim[a]) << FRAC_BITS;
      c_ovr[a] = c_ext[a] > c_lim[a];
      c_sat[a] = c_ovr[a] ? c_lim[a] : c_ext[a];
      c_inr[a] = (c_ext[a] >> FRAC_BITS) <= CMP_W'(lim[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= opcode_i;
      flag_q     <= |c_ovr;
      in_range_q <= &c_inr;
      wdata_q    <= sample_value_i;
      for (int a = 0; a < 3; a++) begin
        base_q[a] <= c_sat[a][FRAC_BITS +: IDX_W];
        frac_q[a] <= c_sat[a][FRAC_BITS-1:0];
      end
    end
  end

  assign status_o.is_query = (op_q == OP_QUERY);

  // base cell address: (x*sy + y)*sz + z as x*(sy*sz) + y*sz + z
  logic [ADDR_W-1:0] a0_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr) begin
      a0_q <= ADDR_W'(SUM_W'(base_q[0]) * SUM_W'(syz_q)
                    + SUM_W'(base_q[1]) * SUM_W'(sz_eff)
                    + SUM_W'(base_q[2]));
    end
  end

  // corner address and weights
  logic [2:0]        up;
  logic [ADDR_W-1:0] rd_addr;
  logic [WF_W-1:0]   wsel [3];
  logic              skip;

  always_comb begin
    up = {cmd_i.corner[0], cmd_i.corner[1], cmd_i.corner[2]};  // up[a] per axis
    skip = 1'b0;
    for (int a = 0; a < 3; a++) begin
      wsel[a] = up[a] ? WF_W'(frac_q[a]) : ONE_FRAC - WF_W'(frac_q[a]);
      skip    = skip | (up[a] && (frac_q[a] == '0));
    end
    rd_addr = a0_q
            + ((up[0] && base_q[0] != lim[0]) ? ADDR_W'(syz_q)  : '0)
            + ((up[1] && base_q[1] != lim[1]) ? ADDR_W'(sz_eff) : '0)
            + ((up[2] && base_q[2] != lim[2]) ? ADDR_W'(1)      : '0);
  end

  // sample store, single port
  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [SAMPLE_BITS-1:0] rd_q;
  logic [ADDR_W-1:0]      mem_addr;

  assign mem_addr = cmd_i.write ? a0_q : rd_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && in_range_q) begin
      mem[mem_addr] <= wdata_q;
    end
    if (cmd_i.issue) begin
      rd_q <= mem[mem_addr];
    end
  end

  // MAC pipe
  logic                          v1_q, v2_q, v3_q;
  logic [WXY_W-1:0]              wxy_q;
  logic [WF_W-1:0]               wz_q;
  logic                          skip_q;
  logic [W_W-1:0]                w_q;
  logic signed [SAMPLE_BITS-1:0] samp_q;
  logic signed [W_W:0]           w_ext;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [ACC_W-1:0]       acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign w_ext = {1'b0, w_q};

  always_ff @(posedge clk_i) begin
    wxy_q  <= WXY_W'(wsel[0]) * WXY_W'(wsel[1]);
    wz_q   <= wsel[2];
    skip_q <= skip;
    // zero-weight corners contribute nothing, whatever the store returned
    samp_q <= skip_q ? '0 : rd_q;
    w_q    <= W_W'(wxy_q) * W_W'(wz_q);
    prod_q <= PROD_W'(samp_q) * PROD_W'(w_ext);
    if (cmd_i.load) begin
      acc_q <= '0;
    end else if (v3_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // round half up, floor shift, saturate
  logic signed [ACC_W-1:0]             rnd;
  logic signed [ACC_W-1:0]             shr;
  logic signed [V_W-1:0]               vsh;
  logic signed [SAMPLE_BITS-1:0]       vsat;
  logic signed [SAMPLE_BITS+OUT_W-1:0] vext;
  logic signed [OUT_W-1:0]             interp_q;
  logic                                clamp_q;

  always_comb begin
    rnd = acc_q + ROUND_HALF;
    shr = rnd >>> SHIFT;
    vsh = shr[V_W-1:0];
    if (vsh > V_HI) begin
      vsat = V_HI[SAMPLE_BITS-1:0];
    end else if (vsh < V_LO) begin
      vsat = V_LO[SAMPLE_BITS-1:0];
    end else begin
      vsat = vsh[SAMPLE_BITS-1:0];
    end
    vext = (SAMPLE_BITS + OUT_W)'(vsat);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result) begin
      interp_q <= vext[OUT_W-1:0];
      clamp_q  <= flag_q;
    end
  end

  assign interp_value_o  = interp_q;
  assign coord_clamped_o = clamp_q;

endmodule

### hdl/trilinear_grid_interpolator.sv
// Channel   Handshake                 Payload
// in        in_valid_i / in_ready_o   opcode_i, coord_x_i, coord_y_i, coord_z_i,
//                                     sample_value_i
// out       out_valid_o / out_ready_i interp_value_o, coord_clamped_o
// cfg       cfg_we_i (no wait)        cfg_index_i, cfg_data_i
//
// A write item steps through accept, base address and store.
// A query item steps through accept, base address, 8 corner reads through the
// single store port, emptying of the weight/multiply/accumulate pipe and rounding
// into the output register before the next item can be taken. The single store
// port serializes the 8 corner reads.
// Reset clears control and size registers only; the store holds no valid bits.
// A new item is taken while a result waits in the output register; a query
// holds in its final cycle until that register is free.
module trilinear_grid_interpolator #(
  parameter int unsigned AXIS_MAX    = 16,
  parameter int unsigned FRAC_BITS   = 8,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [tgi_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tgi_pkg::SIZE_W-1:0]       cfg_data_i,
  // item input
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             opcode_i,
  input  logic [tgi_pkg::COORD_W-1:0]      coord_x_i,
  input  logic [tgi_pkg::COORD_W-1:0]      coord_y_i,
  input  logic [tgi_pkg::COORD_W-1:0]      coord_z_i,
  input  logic signed [SAMPLE_BITS-1:0]    sample_value_i,
  // result output
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [tgi_pkg::OUT_W-1:0] interp_value_o,
  output logic                             coord_clamped_o
);
  import tgi_pkg::*;

  tgi_cmd_t    cmd;
  tgi_status_t status;

  // Sequencer: walks accept -> address -> store for a write, or corners -> drain -> result for a query.
  tgi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Size registers, coordinate saturation, sample store, MAC pipe, rounding.
  tgi_datapath #(
    .AXIS_MAX    (AXIS_MAX),
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .opcode_i        (opcode_i),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .coord_z_i       (coord_z_i),
    .sample_value_i  (sample_value_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .interp_value_o  (interp_value_o),
    .coord_clamped_o (coord_clamped_o)
  );

endmodule
